[hdl/ldf_pkg.sv]
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared constants and types for the length-prefixed deframer.
// ----------------------------------------------------------------------------
package ldf_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned LENGTH_START = 4;
    localparam int unsigned HCOUNT_W     = 4;

    localparam logic [HCOUNT_W-1:0] HDR_LAST    = HCOUNT_W'(HEADER_BYTES - 1);
    localparam logic [HCOUNT_W-1:0] HDR_PAYLOAD = HCOUNT_W'(HEADER_BYTES);
    localparam logic [HCOUNT_W-1:0] HDR_LEN_LO  = HCOUNT_W'(LENGTH_START);

    typedef logic [HCOUNT_W-1:0] hcount_t;

    typedef struct packed {
        logic        has_payload;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic [31:0] frame_seq;
        logic [31:0] frame_length;
        logic        chunk_end;
        logic        chunk_aligned;
    } result_t;

endpackage

[hdl/ldf_if.sv]
// ----------------------------------------------------------------------------
// ldf_if
// Valid/ready channels for the deframer: byte input and result output.
// ----------------------------------------------------------------------------
interface ldf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_last;

    modport source (output valid, output data_byte, output chunk_last, input ready);
    modport sink   (input valid, input data_byte, input chunk_last, output ready);
endinterface

interface ldf_out_if;
    logic        valid;
    logic        ready;
    logic        has_payload;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [31:0] frame_seq;
    logic [31:0] frame_length;
    logic        chunk_end;
    logic        chunk_aligned;

    modport source (output valid, output has_payload, output payload_byte,
                    output last_of_frame, output frame_seq, output frame_length,
                    output chunk_end, output chunk_aligned, input ready);
    modport sink   (input valid, input has_payload, input payload_byte,
                    input last_of_frame, input frame_seq, input frame_length,
                    input chunk_end, input chunk_aligned, output ready);
endinterface

[hdl/length_prefixed_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_deframer
// Splits a byte stream of length-prefixed frames into tagged payload bytes.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle on rx whenever the result buffer has room,
// so the sustained rate is one byte per clock with results taken every cycle.
// A frame is an 8-byte header (4 ignored sequence bytes, then a big-endian
// 32-bit payload length) followed by the payload. Each payload byte comes out
// on res with the local frame count, the length and a last-of-frame mark; an
// empty frame gives one result without payload. A byte with chunk_last set
// always gives a result, reporting whether the chunk ended between frames.
// Header bytes otherwise give nothing. Results are registered in a two-entry
// output buffer that absorbs a stall on res.
module length_prefixed_deframer
(
    input  logic       clk,
    input  logic       rst_n,
    ldf_in_if.sink     rx,
    ldf_out_if.source  res
);

    logic             emit;
    logic             take;
    logic             space;
    ldf_pkg::result_t result;
    ldf_pkg::result_t out_data;

    assign rx.ready = space;
    assign take     = rx.valid && space;

    ldf_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (rx.data_byte),
        .chunk_last (rx.chunk_last),
        .emit       (emit),
        .result     (result)
    );

    ldf_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && emit),
        .push_data (result),
        .space     (space),
        .valid     (res.valid),
        .ready     (res.ready),
        .data      (out_data)
    );

    assign res.has_payload   = out_data.has_payload;
    assign res.payload_byte  = out_data.payload_byte;
    assign res.last_of_frame = out_data.last_of_frame;
    assign res.frame_seq     = out_data.frame_seq;
    assign res.frame_length  = out_data.frame_length;
    assign res.chunk_end     = out_data.chunk_end;
    assign res.chunk_aligned = out_data.chunk_aligned;

endmodule

[hdl/ldf_core.sv]
// ----------------------------------------------------------------------------
// ldf_core
// Frame parser state: header counter, length shifter, payload countdown and
// frame counter. Builds one result per accepted byte when one is due.
// ----------------------------------------------------------------------------
module ldf_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       data_byte,
    input  logic             chunk_last,
    output logic             emit,
    output ldf_pkg::result_t result
);

    ldf_pkg::hcount_t header_count_reg, header_count_next;
    logic [31:0]      length_shift_reg, length_shift_next;
    logic [31:0]      remaining_reg, remaining_next;
    logic [31:0]      frame_counter_reg, frame_counter_next;

    logic in_payload;
    logic frame_done;
    logic [31:0] shifted;

    assign in_payload = (header_count_reg == ldf_pkg::HDR_PAYLOAD);
    assign shifted    = {length_shift_reg[23:0], data_byte};

    always_comb
    begin
        header_count_next  = header_count_reg;
        length_shift_next  = length_shift_reg;
        remaining_next     = remaining_reg;
        frame_counter_next = frame_counter_reg;
        frame_done         = 1'b0;
        emit               = 1'b0;
        result             = '0;

        if (!in_payload)
        begin
            if (header_count_reg >= ldf_pkg::HDR_LEN_LO)
                length_shift_next = shifted;
            header_count_next = header_count_reg + ldf_pkg::hcount_t'(1);
            if (header_count_reg == ldf_pkg::HDR_LAST)
            begin
                // last header byte: length is complete in shifted
                remaining_next = shifted;
                if (shifted == 32'd0)
                begin
                    emit                 = 1'b1;
                    frame_done           = 1'b1;
                    result.last_of_frame = 1'b1;
                    result.frame_seq     = frame_counter_reg;
                end
            end
        end
        else
        begin
            emit                = 1'b1;
            result.has_payload  = 1'b1;
            result.payload_byte = data_byte;
            result.frame_seq    = frame_counter_reg;
            result.frame_length = length_shift_reg;
            remaining_next      = remaining_reg - 32'd1;
            if (remaining_reg == 32'd1)
            begin
                frame_done           = 1'b1;
                result.last_of_frame = 1'b1;
            end
        end

        if (frame_done)
        begin
            frame_counter_next = frame_counter_reg + 32'd1;
            header_count_next  = '0;
        end

        if (chunk_last)
        begin
            emit                 = 1'b1;
            result.chunk_end     = 1'b1;
            result.chunk_aligned = frame_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg  <= '0;
            length_shift_reg  <= '0;
            remaining_reg     <= '0;
            frame_counter_reg <= '0;
        end
        else if (take)
        begin
            header_count_reg  <= header_count_next;
            length_shift_reg  <= length_shift_next;
            remaining_reg     <= remaining_next;
            frame_counter_reg <= frame_counter_next;
        end
    end

endmodule

[hdl/ldf_out_buf.sv]
// ----------------------------------------------------------------------------
// ldf_out_buf
// Output register with a skid stage; ready toward the core is registered.
// ----------------------------------------------------------------------------
module ldf_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ldf_pkg::result_t push_data,
    output logic             space,
    output logic             valid,
    input  logic             ready,
    output ldf_pkg::result_t data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    ldf_pkg::result_t main_reg, main_next;
    ldf_pkg::result_t skid_reg, skid_next;
    logic             pop;

    assign pop   = main_valid_reg && ready;
    assign space = !skid_valid_reg;
    assign valid = main_valid_reg;
    assign data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // no push possible while the skid is full
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
